### hw/rtl/vertex_weld_dedup_table_defines.svh
// Assertion macros shared by the vertex weld table RTL.
// Depends on nothing; users provide i_clk and i_rst_n in scope.
`ifndef VERTEX_WELD_DEDUP_TABLE_DEFINES_SVH
`define VERTEX_WELD_DEDUP_TABLE_DEFINES_SVH
`ifndef ASSERT_OFF
`define VWDT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("vertex weld table: property violated");
`define VWDT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("vertex weld table: forbidden condition");
`else
`define VWDT_ASSERT(lbl, prop)
`define VWDT_NEVER(lbl, cond)
`endif
`endif

### hw/rtl/vwdt_pkg.sv
// Shared types and constants of the vertex weld table.
// Used by vwdt_scan and vertex_weld_dedup_table; depends on nothing.
package vwdt_pkg;

    localparam int MAX_UNIQUE = 1024;
    localparam int MAX_INPUT  = 4096;
    localparam int COORD_BITS = 24;

    localparam int UIDX_W = $clog2(MAX_UNIQUE);
    localparam int UCNT_W = UIDX_W + 1;
    localparam int RIDX_W = $clog2(MAX_INPUT);
    localparam int RCNT_W = RIDX_W + 1;
    localparam int TOL_W  = 52;
    localparam int OIDX_W = 10;

    localparam logic [63:0] AXIS_CAP = 64'd1 << 26;
    localparam int MAG_W = 27;
    localparam int SQ_W  = 2 * MAG_W;
    localparam int SUM_W = SQ_W + 2;

    localparam logic [1:0] ACT_VERTEX   = 2'd0;
    localparam logic [1:0] ACT_TRIANGLE = 2'd1;
    localparam logic [1:0] ACT_CLEAR    = 2'd2;

    typedef struct packed {
        logic        [1:0]            action;
        logic signed [COORD_BITS-1:0] coord_x;
        logic signed [COORD_BITS-1:0] coord_y;
        logic signed [COORD_BITS-1:0] coord_z;
        logic        [11:0]           corner_first;
        logic        [11:0]           corner_second;
        logic        [11:0]           corner_third;
    } t_in_item;

    typedef struct packed {
        logic [OIDX_W-1:0] welded_index;
        logic              is_new;
        logic              overflow;
        logic              keep_triangle;
        logic [OIDX_W-1:0] out_first;
        logic [OIDX_W-1:0] out_second;
        logic [OIDX_W-1:0] out_third;
    } t_out_item;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } t_pos;

    typedef struct packed {
        logic              hit;
        logic              nomatch;
        logic [UIDX_W-1:0] idx;
    } t_scan_stat;

endpackage

### hw/rtl/vertex_weld_dedup_table.sv
// Vertex weld table: control, remap memory and configuration port.
// Depends on vwdt_pkg, vwdt_scan and vertex_weld_dedup_table_defines.svh.
//
// One item at a time; start is taken while busy is low, and each item gives
// exactly one result, shown for one cycle with o_done. The receiver cannot
// stall, so capture o_result whenever o_done is high. A vertex item that finds
// no match scans every stored unique position: the unique position memory is
// read one entry per cycle, each entry passes the read register, the axis
// magnitude register and the square register before the compare, the scan
// ends once the pipeline is drained, and a finish state records the result.
// A first match at entry j ends the scan early. A triangle item reads the
// remap memory three times, one corner at a time. Clear, unused actions and
// a vertex arriving with the remap table full give their result on the cycle
// after start with no busy time.
// tolerance_squared lives at byte address 0 of the 64-bit register port.
`include "vertex_weld_dedup_table_defines.svh"
module vertex_weld_dedup_table
    import vwdt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in_item    i_item,
    output logic        o_done,
    output t_out_item   o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_FINISH = 4'b0100,
        S_TRI    = 4'b1000
    } t_state;

    t_state            r_state;
    logic [UCNT_W-1:0] r_ucount;
    logic [RCNT_W-1:0] r_ivc;
    logic [TOL_W-1:0]  r_tol;
    logic              r_done;
    t_out_item         r_result;
    t_pos              r_pos;
    logic              r_found;
    logic [UIDX_W-1:0] r_match_idx;
    logic [1:0]        r_tri_cnt;
    logic [11:0]       r_corner [3];
    logic              r_rd_ok;
    logic [UIDX_W-1:0] r_tri_val [2];
    logic [UIDX_W-1:0] r_remap_mem [MAX_INPUT];
    logic [UIDX_W-1:0] r_remap_q;

    t_scan_stat        scan_stat;
    logic              accept;
    logic              ivc_full;
    logic              ucount_full;
    logic              scan_start;
    logic              pos_wr;
    logic              remap_wr;
    logic [UIDX_W-1:0] final_idx;
    logic              remap_rd;
    logic [11:0]       corner_sel;
    logic [UIDX_W-1:0] rd_val;
    logic              cfg_wr;
    logic              n_done;
    t_out_item         start_result;

    assign accept      = start && (r_state == S_IDLE);
    assign busy        = (r_state != S_IDLE);
    assign ivc_full    = (r_ivc == RCNT_W'(MAX_INPUT));
    assign ucount_full = (r_ucount == UCNT_W'(MAX_UNIQUE));
    assign scan_start  = accept && (i_item.action == ACT_VERTEX) && !ivc_full;
    assign pos_wr      = (r_state == S_FINISH) && !r_found && !ucount_full;
    assign remap_wr    = (r_state == S_FINISH);
    assign remap_rd    = (r_state == S_TRI) && (r_tri_cnt != 2'd3);
    assign rd_val      = r_rd_ok ? r_remap_q : '0;
    assign cfg_wr      = psel && penable && pwrite && !paddr[3];
    assign n_done      = (accept && !scan_start && (i_item.action != ACT_TRIANGLE))
                      || (r_state == S_FINISH)
                      || ((r_state == S_TRI) && (r_tri_cnt == 2'd3));

    assign o_done   = r_done;
    assign o_result = r_result;
    assign pready   = 1'b1;
    assign prdata   = paddr[3] ? 64'd0 : 64'(r_tol);

    always_comb begin
        priority if (r_found) begin
            final_idx = r_match_idx;
        end else if (!ucount_full) begin
            final_idx = r_ucount[UIDX_W-1:0];
        end else begin
            final_idx = '0;
        end
    end

    always_comb begin
        unique case (r_tri_cnt)
            2'd0:    corner_sel = r_corner[0];
            2'd1:    corner_sel = r_corner[1];
            default: corner_sel = r_corner[2];
        endcase
    end

    always_comb begin
        start_result          = '0;
        start_result.overflow = (i_item.action == ACT_VERTEX) && ivc_full;
    end

    vwdt_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (scan_start),
        .i_count   (r_ucount),
        .i_coord   (r_pos),
        .i_tol     (r_tol),
        .i_wr_en   (pos_wr),
        .i_wr_addr (r_ucount[UIDX_W-1:0]),
        .i_wr_data (r_pos),
        .o_stat    (scan_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ucount  <= '0;
            r_ivc     <= '0;
            r_tol     <= TOL_W'(1);
            r_done    <= 1'b0;
            r_tri_cnt <= '0;
        end else begin
            r_done <= n_done;
            if (cfg_wr) begin
                r_tol <= pwdata[TOL_W-1:0];
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        unique case (i_item.action)
                            ACT_VERTEX: begin
                                if (!ivc_full) begin
                                    r_state <= S_SCAN;
                                end
                            end
                            ACT_TRIANGLE: begin
                                r_tri_cnt <= '0;
                                r_state   <= S_TRI;
                            end
                            ACT_CLEAR: begin
                                r_ucount <= '0;
                                r_ivc    <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (scan_stat.hit || scan_stat.nomatch) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (pos_wr) begin
                        r_ucount <= r_ucount + 1'b1;
                    end
                    r_ivc   <= r_ivc + 1'b1;
                    r_state <= S_IDLE;
                end
                S_TRI: begin
                    r_tri_cnt <= r_tri_cnt + 1'b1;
                    if (r_tri_cnt == 2'd3) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pos.x     <= i_item.coord_x;
            r_pos.y     <= i_item.coord_y;
            r_pos.z     <= i_item.coord_z;
            r_corner[0] <= i_item.corner_first;
            r_corner[1] <= i_item.corner_second;
            r_corner[2] <= i_item.corner_third;
            r_result    <= start_result;
        end
        if (r_state == S_SCAN) begin
            r_found     <= scan_stat.hit;
            r_match_idx <= scan_stat.idx;
        end
        if (r_state == S_FINISH) begin
            r_result.welded_index <= OIDX_W'(final_idx);
            r_result.is_new       <= pos_wr;
            r_result.overflow     <= !r_found && ucount_full;
        end
        if (r_state == S_TRI) begin
            r_rd_ok <= (RCNT_W'(corner_sel) < r_ivc);
            unique case (r_tri_cnt)
                2'd1: r_tri_val[0] <= rd_val;
                2'd2: r_tri_val[1] <= rd_val;
                2'd3: begin
                    r_result.out_first     <= OIDX_W'(r_tri_val[0]);
                    r_result.out_second    <= OIDX_W'(r_tri_val[1]);
                    r_result.out_third     <= OIDX_W'(rd_val);
                    r_result.keep_triangle <= (r_tri_val[0] != r_tri_val[1])
                                           && (r_tri_val[1] != rd_val)
                                           && (r_tri_val[0] != rd_val);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (remap_wr) begin
            r_remap_mem[r_ivc[RIDX_W-1:0]] <= final_idx;
        end
        if (remap_rd) begin
            r_remap_q <= r_remap_mem[corner_sel[RIDX_W-1:0]];
        end
    end

    `VWDT_ASSERT(a_done_source, o_done |-> $past(accept) || $past(r_state == S_FINISH)
        || $past(r_state == S_TRI))
    `VWDT_ASSERT(a_ucount_bound, r_ucount <= UCNT_W'(MAX_UNIQUE))
    `VWDT_ASSERT(a_ivc_bound, r_ivc <= RCNT_W'(MAX_INPUT))
    `VWDT_ASSERT(a_scan_room, (r_state == S_SCAN) |-> !ivc_full)
    `VWDT_ASSERT(a_new_is_last, (o_done && o_result.is_new)
        |-> (o_result.welded_index == OIDX_W'(r_ucount - 1'b1)) && !o_result.overflow)

endmodule

### hw/rtl/vwdt_scan.sv
// Unique position memory and the pipelined distance scan over it.
// Depends on vwdt_pkg and vertex_weld_dedup_table_defines.svh.
`include "vertex_weld_dedup_table_defines.svh"
module vwdt_scan
    import vwdt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [UCNT_W-1:0]  i_count,
    input  t_pos               i_coord,
    input  logic [TOL_W-1:0]   i_tol,
    input  logic               i_wr_en,
    input  logic [UIDX_W-1:0]  i_wr_addr,
    input  t_pos               i_wr_data,
    output t_scan_stat         o_stat
);

    localparam int EXT_W = COORD_BITS + 28;
    localparam logic [EXT_W-1:0] CAP_EXT = EXT_W'(AXIS_CAP);

    function automatic logic [MAG_W-1:0] axis_mag(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] b
    );
        logic [COORD_BITS:0] d;
        logic [COORD_BITS:0] m;
        logic [EXT_W-1:0]    e;
        d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        m = d[COORD_BITS] ? (~d + 1'b1) : d;
        e = EXT_W'(m);
        return (e > CAP_EXT) ? MAG_W'(AXIS_CAP) : e[MAG_W-1:0];
    endfunction

    t_pos              r_mem [MAX_UNIQUE];
    t_pos              r_rd_q;
    logic              r_active;
    logic [UCNT_W-1:0] r_rd_idx;
    logic              r_v1, r_v2, r_v3;
    logic [UIDX_W-1:0] r_idx1, r_idx2, r_idx3;
    logic [MAG_W-1:0]  r_mag [3];
    logic [SQ_W-1:0]   r_sq  [3];

    logic              rd_en;
    logic              hit;
    logic              nomatch;
    logic [SUM_W-1:0]  sq_sum;

    assign rd_en   = r_active && (r_rd_idx < i_count);
    assign sq_sum  = SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
    assign hit     = r_active && r_v3 && (sq_sum < SUM_W'(i_tol));
    assign nomatch = r_active && !rd_en && !r_v1 && !r_v2 && !r_v3;

    assign o_stat.hit     = hit;
    assign o_stat.nomatch = nomatch;
    assign o_stat.idx     = r_idx3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_rd_idx <= '0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
        end else begin
            if (i_start) begin
                r_active <= 1'b1;
                r_rd_idx <= '0;
            end else begin
                if (hit || nomatch) begin
                    r_active <= 1'b0;
                end
                if (rd_en) begin
                    r_rd_idx <= r_rd_idx + 1'b1;
                end
            end
            r_v1 <= rd_en && !hit;
            r_v2 <= r_v1 && !hit;
            r_v3 <= r_v2 && !hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (rd_en) begin
            r_rd_q <= r_mem[r_rd_idx[UIDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx1   <= r_rd_idx[UIDX_W-1:0];
        r_idx2   <= r_idx1;
        r_idx3   <= r_idx2;
        r_mag[0] <= axis_mag(r_rd_q.x, i_coord.x);
        r_mag[1] <= axis_mag(r_rd_q.y, i_coord.y);
        r_mag[2] <= axis_mag(r_rd_q.z, i_coord.z);
        r_sq[0]  <= SQ_W'(r_mag[0]) * SQ_W'(r_mag[0]);
        r_sq[1]  <= SQ_W'(r_mag[1]) * SQ_W'(r_mag[1]);
        r_sq[2]  <= SQ_W'(r_mag[2]) * SQ_W'(r_mag[2]);
    end

    `VWDT_NEVER(a_wr_during_scan, i_wr_en && rd_en)
    `VWDT_ASSERT(a_hit_flushes, hit |=> !r_v1 && !r_v2 && !r_v3)
    `VWDT_ASSERT(a_idx_in_table, r_v3 |-> (UCNT_W'(r_idx3) < i_count))

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for vertex_weld_dedup_table: a queue-fed driver sends
// vertex, triangle and clear items, predicts every result and checks it field by field.
// Depends on vwdt_pkg and the vertex_weld_dedup_table RTL.
module tb;
    import vwdt_pkg::*;

    localparam int         HALF_PERIOD   = 4;
    localparam int         RESET_CYCLES  = 10;
    localparam longint     CYCLE_LIMIT   = 4000000;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         TAIL_CYCLES   = 40;
    localparam int         MAX_REPORTS   = 10;
    localparam int         PHASES        = 8;
    localparam int         PHASE_ITEMS   = 60;
    localparam int         COORD_MAX     = (1 << (COORD_BITS - 1)) - 1;
    localparam int         COORD_MIN     = -(1 << (COORD_BITS - 1));
    localparam logic [3:0] ADDR_TOL      = 4'd0;
    localparam logic [1:0] ACT_UNUSED    = 2'd3;
    localparam logic [TOL_W-1:0] TOL_MAX = '1;

    typedef enum logic [1:0] {OP_ITEM, OP_DRAIN, OP_CFG} t_op_kind;
    typedef enum logic [2:0] {
        DS_GAP, DS_ITEM, DS_DRAIN, DS_SETUP, DS_ACCESS, DS_RSETUP, DS_RACCESS, DS_DONE
    } t_drv_state;

    typedef struct {
        t_op_kind    kind;
        t_in_item    item;
        logic [63:0] value;
        int          gap;
    } t_op;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start   = 1'b0;
    logic        busy;
    t_in_item    i_item  = '0;
    logic        o_done;
    t_out_item   o_result;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = '0;
    logic [63:0] pwdata  = '0;
    logic [63:0] prdata;
    logic        pready;

    vertex_weld_dedup_table i_dut (
        .i_clk, .i_rst_n, .start, .busy, .i_item, .o_done, .o_result,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    // weld table prediction state
    t_pos              kept_pos [MAX_UNIQUE];
    int unsigned       kept_count = 0;
    logic [UIDX_W-1:0] remap_of [MAX_INPUT];
    int unsigned       vert_count = 0;
    logic [TOL_W-1:0]  tol_sq     = TOL_W'(1);

    t_out_item  weld_expect_q [$];
    t_op        op_q [$];
    t_drv_state drv_state   = DS_GAP;
    int         gap_left    = 0;
    int         settle_left = 0;
    int         calm_left   = 0;
    bit         stim_done   = 1'b0;
    longint     cycle_count = 0;

    int mismatches = 0;
    int n_vertex = 0, n_triangle = 0, n_clear = 0, n_unused = 0, n_writes = 0;
    int n_results = 0, n_new = 0, n_ovf = 0, n_kept = 0;

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic void flag_error(string msg);
        if (mismatches < MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
        mismatches++;
    endfunction

    function automatic string fmt_result(t_out_item r);
        return $sformatf("idx=%0d new=%0b ovf=%0b keep=%0b corners=%0d,%0d,%0d",
                         r.welded_index, r.is_new, r.overflow, r.keep_triangle,
                         r.out_first, r.out_second, r.out_third);
    endfunction

    function automatic logic [63:0] axis_sq(logic signed [COORD_BITS-1:0] a,
                                            logic signed [COORD_BITS-1:0] b);
        longint m;
        m = longint'(a) - longint'(b);
        if (m < 0) begin
            m = -m;
        end
        return 64'(m * m);
    endfunction

    function automatic logic [UIDX_W-1:0] corner_remap(logic [11:0] c);
        if (c >= vert_count) begin
            return '0;
        end
        return remap_of[c];
    endfunction

    function automatic t_out_item weld_predict(t_in_item it);
        t_out_item         r;
        logic [63:0]       sq_dist;
        logic [UIDX_W-1:0] a, b, c, idx;
        bit                found;
        r     = '0;
        found = 1'b0;
        idx   = '0;
        case (it.action)
            ACT_CLEAR: begin
                kept_count = 0;
                vert_count = 0;
            end
            ACT_VERTEX: begin
                if (vert_count >= MAX_INPUT) begin
                    r.overflow = 1'b1;
                end else begin
                    for (int j = 0; j < kept_count && !found; j++) begin
                        sq_dist = axis_sq(kept_pos[j].x, it.coord_x)
                                + axis_sq(kept_pos[j].y, it.coord_y)
                                + axis_sq(kept_pos[j].z, it.coord_z);
                        if (sq_dist < {{(64-TOL_W){1'b0}}, tol_sq}) begin
                            found = 1'b1;
                            idx   = UIDX_W'(j);
                        end
                    end
                    if (!found) begin
                        if (kept_count < MAX_UNIQUE) begin
                            idx = UIDX_W'(kept_count);
                            kept_pos[kept_count] = '{x: it.coord_x, y: it.coord_y, z: it.coord_z};
                            kept_count++;
                            r.is_new = 1'b1;
                        end else begin
                            r.overflow = 1'b1;
                        end
                    end
                    remap_of[vert_count] = idx;
                    vert_count++;
                    r.welded_index = idx;
                end
            end
            ACT_TRIANGLE: begin
                a = corner_remap(it.corner_first);
                b = corner_remap(it.corner_second);
                c = corner_remap(it.corner_third);
                r.keep_triangle = (a != b) && (b != c) && (a != c);
                r.out_first  = a;
                r.out_second = b;
                r.out_third  = c;
            end
            default: ;
        endcase
        return r;
    endfunction

    // driver: items, drain pauses and register write/readback from op_q
    always @(posedge i_clk) begin
        t_op nxt;
        bit  take;
        if (!i_rst_n) begin
            start     <= 1'b0;
            i_item    <= '0;
            psel      <= 1'b0;
            penable   <= 1'b0;
            pwrite    <= 1'b0;
            paddr     <= ADDR_TOL;
            pwdata    <= '0;
            drv_state <= DS_GAP;
            gap_left  <= 0;
        end else begin
            take = 1'b0;
            case (drv_state)
                DS_GAP: begin
                    if (gap_left != 0) gap_left <= gap_left - 1;
                    else take = 1'b1;
                end
                DS_ITEM: begin
                    if (!busy) begin
                        case (i_item.action)
                            ACT_VERTEX:   n_vertex++;
                            ACT_TRIANGLE: n_triangle++;
                            ACT_CLEAR:    n_clear++;
                            default:      n_unused++;
                        endcase
                        weld_expect_q.insert(weld_expect_q.size(), weld_predict(i_item));
                        take = 1'b1;
                    end
                end
                DS_DRAIN: begin
                    if (weld_expect_q.size() != 0 || busy) settle_left <= SETTLE_CYCLES;
                    else if (settle_left != 0) settle_left <= settle_left - 1;
                    else take = 1'b1;
                end
                DS_SETUP: begin
                    penable   <= 1'b1;
                    drv_state <= DS_ACCESS;
                end
                DS_ACCESS: begin
                    if (pready) begin
                        tol_sq = pwdata[TOL_W-1:0];
                        n_writes++;
                        penable   <= 1'b0;
                        pwrite    <= 1'b0;
                        drv_state <= DS_RSETUP;
                    end
                end
                DS_RSETUP: begin
                    penable   <= 1'b1;
                    drv_state <= DS_RACCESS;
                end
                DS_RACCESS: begin
                    if (pready) begin
                        if (prdata !== {{(64-TOL_W){1'b0}}, tol_sq}) begin
                            flag_error($sformatf("tolerance readback: expected %0d, got %0d",
                                                 tol_sq, prdata));
                        end
                        take = 1'b1;
                    end
                end
                default: ;
            endcase
            if (take) begin
                if (op_q.size() == 0) begin
                    start     <= 1'b0;
                    psel      <= 1'b0;
                    penable   <= 1'b0;
                    pwrite    <= 1'b0;
                    drv_state <= DS_DONE;
                    stim_done <= 1'b1;
                end else if (op_q[0].kind == OP_ITEM && op_q[0].gap != 0
                             && drv_state != DS_GAP) begin
                    start     <= 1'b0;
                    psel      <= 1'b0;
                    penable   <= 1'b0;
                    pwrite    <= 1'b0;
                    gap_left  <= op_q[0].gap - 1;
                    drv_state <= DS_GAP;
                end else begin
                    nxt = op_q.pop_front();
                    start   <= (nxt.kind == OP_ITEM);
                    psel    <= (nxt.kind == OP_CFG);
                    pwrite  <= (nxt.kind == OP_CFG);
                    penable <= 1'b0;
                    case (nxt.kind)
                        OP_ITEM: begin
                            i_item    <= nxt.item;
                            drv_state <= DS_ITEM;
                        end
                        OP_DRAIN: begin
                            settle_left <= SETTLE_CYCLES;
                            drv_state   <= DS_DRAIN;
                        end
                        default: begin
                            paddr     <= ADDR_TOL;
                            pwdata    <= nxt.value;
                            drv_state <= DS_SETUP;
                        end
                    endcase
                end
            end
        end
    end

    // monitor: every strobed result against the oldest prediction
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_done) begin
            n_results++;
            if (weld_expect_q.size() == 0) begin
                flag_error($sformatf("result %0d with nothing pending: %s",
                                     n_results, fmt_result(o_result)));
            end else begin
                want = weld_expect_q.pop_front();
                n_new  += want.is_new;
                n_ovf  += want.overflow;
                n_kept += want.keep_triangle;
                if (o_result.welded_index !== want.welded_index
                    || o_result.is_new !== want.is_new
                    || o_result.overflow !== want.overflow
                    || o_result.keep_triangle !== want.keep_triangle
                    || o_result.out_first !== want.out_first
                    || o_result.out_second !== want.out_second
                    || o_result.out_third !== want.out_third) begin
                    flag_error($sformatf("result %0d: expected %s, got %s", n_results,
                                         fmt_result(want), fmt_result(o_result)));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, weld_expect_q.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int draw_gap();
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm_left = $urandom_range(10, 60);
        end
        return $urandom_range(0, 11);
    endfunction

    function automatic int rand_coord();
        logic signed [COORD_BITS-1:0] v;
        v = COORD_BITS'($urandom);
        return int'(v);
    endfunction

    function automatic int clamp_coord(int v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return v;
    endfunction

    function automatic t_in_item noise_item(logic [1:0] act);
        t_in_item it;
        it.action        = act;
        it.coord_x       = COORD_BITS'($urandom);
        it.coord_y       = COORD_BITS'($urandom);
        it.coord_z       = COORD_BITS'($urandom);
        it.corner_first  = 12'($urandom);
        it.corner_second = 12'($urandom);
        it.corner_third  = 12'($urandom);
        return it;
    endfunction

    task automatic push_item(t_in_item it);
        t_op op;
        op = '{kind: OP_ITEM, item: it, value: '0, gap: draw_gap()};
        op_q.insert(op_q.size(), op);
    endtask

    task automatic push_vertex(int x, int y, int z);
        t_in_item it;
        it = noise_item(ACT_VERTEX);
        it.coord_x = COORD_BITS'(x);
        it.coord_y = COORD_BITS'(y);
        it.coord_z = COORD_BITS'(z);
        push_item(it);
    endtask

    task automatic push_triangle(int a, int b, int c);
        t_in_item it;
        it = noise_item(ACT_TRIANGLE);
        it.corner_first  = 12'(a);
        it.corner_second = 12'(b);
        it.corner_third  = 12'(c);
        push_item(it);
    endtask

    task automatic push_tolerance(logic [TOL_W-1:0] v);
        t_op op;
        op = '{kind: OP_DRAIN, item: '0, value: '0, gap: 0};
        op_q.insert(op_q.size(), op);
        op = '{kind: OP_CFG, item: '0, value: {{(64-TOL_W){1'b0}}, v}, gap: 0};
        op_q.insert(op_q.size(), op);
    endtask

    initial begin
        t_pos             mesh_pos [$];
        t_pos             p;
        logic [TOL_W-1:0] tol;
        int               mesh_n, jit, x, y, z, sel, phase_count, mesh_len;

        // reset tolerance: exact repeats weld, unit steps and extremes stay apart
        push_vertex(0, 0, 0);
        push_vertex(0, 0, 0);
        push_vertex(1, 0, 0);
        push_vertex(COORD_MIN, COORD_MIN, COORD_MIN);
        push_vertex(COORD_MAX, COORD_MAX, COORD_MAX);
        push_triangle(0, 1, 2);
        push_triangle(2, 3, 4);
        push_item(noise_item(ACT_UNUSED));
        push_item(noise_item(ACT_CLEAR));
        push_triangle(1, 3, 4);
        push_tolerance(TOL_MAX);
        push_vertex(COORD_MIN, COORD_MIN, COORD_MIN);
        push_vertex(COORD_MAX, COORD_MAX, COORD_MAX);
        push_triangle(0, 1, 0);
        push_tolerance('0);
        push_vertex(5, 5, 5);
        push_vertex(5, 5, 5);
        push_triangle(2, 3, 4);
        push_item(noise_item(ACT_CLEAR));

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       tol = '0;
                1:       tol = TOL_W'(1);
                2:       tol = TOL_MAX;
                3:       tol = TOL_W'(64'd1 << 20);
                4:       tol = TOL_W'(64'd1 << 40);
                5:       tol = TOL_W'({$urandom(), $urandom()});
                6:       tol = TOL_W'(250000);
                default: tol = TOL_W'($urandom_range(0, 1 << 22));
            endcase
            push_tolerance(tol);
            phase_count = 0;
            mesh_n = 0;
            mesh_pos.delete();
            while (phase_count < PHASE_ITEMS) begin
                if ($urandom_range(0, 5) != 0) begin
                    push_item(noise_item(ACT_CLEAR));
                    mesh_n = 0;
                    mesh_pos.delete();
                    phase_count++;
                end
                mesh_len = $urandom_range(4, 30);
                repeat (mesh_len) begin
                    sel = $urandom_range(0, 99);
                    if (sel < 55 || mesh_n == 0) begin
                        if (mesh_pos.size() != 0 && $urandom_range(0, 1) == 1) begin
                            p   = mesh_pos[$urandom_range(0, mesh_pos.size() - 1)];
                            jit = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3)
                                                              : $urandom_range(0, 1500);
                            x = clamp_coord(int'(p.x) + int'($urandom_range(0, 2 * jit)) - jit);
                            y = clamp_coord(int'(p.y) + int'($urandom_range(0, 2 * jit)) - jit);
                            z = clamp_coord(int'(p.z) + int'($urandom_range(0, 2 * jit)) - jit);
                        end else begin
                            x = rand_coord();
                            y = rand_coord();
                            z = rand_coord();
                        end
                        push_vertex(x, y, z);
                        p = '{x: COORD_BITS'(x), y: COORD_BITS'(y), z: COORD_BITS'(z)};
                        mesh_pos.insert(mesh_pos.size(), p);
                        mesh_n++;
                    end else if (sel < 88) begin
                        push_triangle($urandom_range(0, mesh_n - 1), $urandom_range(0, mesh_n - 1),
                                      $urandom_range(0, mesh_n - 1));
                    end else if (sel < 95) begin
                        push_triangle($urandom_range(0, MAX_INPUT - 1),
                                      $urandom_range(0, MAX_INPUT - 1),
                                      $urandom_range(0, MAX_INPUT - 1));
                    end else begin
                        push_item(noise_item(ACT_UNUSED));
                    end
                    phase_count++;
                end
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done);
        while (weld_expect_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("sent %0d vertex, %0d triangle, %0d clear, %0d unused items",
                 n_vertex, n_triangle, n_clear, n_unused);
        $display("%0d tolerance writes; %0d results, %0d new, %0d overflow, %0d kept, %0d errors",
                 n_writes, n_results, n_new, n_ovf, n_kept, mismatches);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/vwdt_pkg.sv
hw/rtl/vwdt_scan.sv
hw/rtl/vertex_weld_dedup_table.sv
tb/sv/tb.sv
